[rtl/msae_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msae_pkg
// Shared types and decode constants for the integer execute block.
// ----------------------------------------------------------------------------
package msae_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned IDX_FIELD_W = 5;

   // operation select
   localparam logic OPER_EXEC = 1'b0;
   localparam logic OPER_LOAD = 1'b1;

   // primary opcodes, instruction bits 30..26
   localparam logic [4:0] OPC_SPECIAL = 5'd0;
   localparam logic [4:0] OPC_ADDI    = 5'd8;
   localparam logic [4:0] OPC_MUL     = 5'd28;

   // function codes under the special opcode
   localparam logic [5:0] FN_SLL  = 6'd0;
   localparam logic [5:0] FN_SRL  = 6'd2;
   localparam logic [5:0] FN_MOVZ = 6'd10;
   localparam logic [5:0] FN_ADD  = 6'd32;
   localparam logic [5:0] FN_SUB  = 6'd34;
   localparam logic [5:0] FN_OR   = 6'd36;
   localparam logic [5:0] FN_AND  = 6'd37;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0] dest;
      logic [DATA_W-1:0]      value;
      logic                   write_req;
      logic                   unknown;
   } alu_result_type;

endpackage

[rtl/msae_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/msae_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msae_alu
// Instruction decode and arithmetic for one item, from resolved operands.
// ----------------------------------------------------------------------------
module msae_alu (
   input  logic                                     operation,
   input  logic [31:0]                              instruction,
   input  logic [msae_pkg::IDX_FIELD_W-1:0]         load_index,
   input  logic [msae_pkg::DATA_W-1:0]              load_data,
   input  logic [msae_pkg::DATA_W-1:0]              opnd_s,
   input  logic [msae_pkg::DATA_W-1:0]              opnd_t,
   input  logic [msae_pkg::DATA_W-1:0]              opnd_d,
   output msae_pkg::alu_result_type                 result
);
   import msae_pkg::*;

   logic [4:0]        opc;
   logic [4:0]        rt;
   logic [4:0]        rd;
   logic [4:0]        sa;
   logic [5:0]        fn;
   logic [DATA_W-1:0] imm_ext;
   logic [DATA_W-1:0] product;
   logic              known;

   assign opc     = instruction[30:26];
   assign rt      = instruction[20:16];
   assign rd      = instruction[15:11];
   assign sa      = instruction[10:6];
   assign fn      = instruction[5:0];
   assign imm_ext = {{16{instruction[15]}}, instruction[15:0]};
   assign product = opnd_s * opnd_t;

   always_comb begin
      result = '0;
      known  = 1'b1;
      if (operation == OPER_LOAD) begin
         result.dest      = load_index;
         result.value     = load_data;
         result.write_req = 1'b1;
      end else begin
         unique case (opc)
            OPC_SPECIAL: begin
               result.dest = rd;
               unique case (fn)
                  FN_ADD:  result.value = opnd_s + opnd_t;
                  FN_SUB:  result.value = opnd_s - opnd_t;
                  FN_SLL:  result.value = opnd_t << sa;
                  FN_SRL:  result.value = opnd_t >> sa;
                  FN_AND:  result.value = opnd_s & opnd_t;
                  FN_OR:   result.value = opnd_s | opnd_t;
                  FN_MOVZ: result.value = (opnd_t == '0) ? opnd_s : opnd_d;
                  default: known = 1'b0;
               endcase
            end
            OPC_ADDI: begin
               result.dest  = rt;
               result.value = opnd_s + imm_ext;
            end
            OPC_MUL: begin
               result.dest  = rd;
               result.value = product;
            end
            default: known = 1'b0;
         endcase
         if (known) begin
            result.write_req = 1'b1;
         end else begin
            result.dest    = '0;
            result.value   = '0;
            result.unknown = 1'b1;
         end
      end
   end

endmodule

[rtl/mips_subset_alu_execute.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_alu_execute
// Integer execute stage with a write-back register file.
//
// Input channel req_*: one transfer is either an instruction word to execute
// (req_operation = 0) or a load value for register req_load_index
// (req_operation = 1). Result channel rsp_*: exactly one transfer per input,
// in order, giving the destination, the value, whether a register was
// written and whether the opcode or function was unsupported.
// An input transfer reads the register file into the operand stage; decode,
// ALU and write-back then complete into the result register when that stage
// advances, which raises rsp_valid.
// One item per cycle is sustained while the receiver takes results; a
// write-back feeds the next item's operands through a bypass register.
// The register file is three copies of a registered-read RAM (rs, rt, rd
// ports) with one valid bit per entry; an entry never written reads zero.
// Reset clears all valid bits and empties both stages at once.
// When the receiver stalls, the result holds and the operand stage keeps
// one further item; after that req_ready drops until a transfer on rsp_.
// ----------------------------------------------------------------------------
module mips_subset_alu_execute #(
   parameter int REG_COUNT = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_operation,
   input  logic [31:0]                             req_instruction,
   input  logic [msae_pkg::IDX_FIELD_W-1:0]        req_load_index,
   input  logic signed [msae_pkg::DATA_W-1:0]      req_load_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [msae_pkg::IDX_FIELD_W-1:0]        rsp_dest_index,
   output logic signed [msae_pkg::DATA_W-1:0]      rsp_result_value,
   output logic                                    rsp_wrote,
   output logic                                    rsp_unknown_op
);
   import msae_pkg::*;

   localparam int ADDR_W = $clog2(REG_COUNT);
   localparam logic [IDX_FIELD_W:0] REG_LIMIT = (IDX_FIELD_W + 1)'(REG_COUNT);

   function automatic logic in_range(input logic [IDX_FIELD_W-1:0] idx);
      return {1'b0, idx} < REG_LIMIT;
   endfunction

   logic                   req_xfer;
   logic                   s1_adv;
   logic                   out_free;

   // operand stage
   logic                   s1_valid_ff;
   logic                   s1_operation_ff;
   logic [31:0]            s1_instruction_ff;
   logic [IDX_FIELD_W-1:0] s1_load_index_ff;
   logic [DATA_W-1:0]      s1_load_data_ff;
   logic                   rs_ok_ff;
   logic                   rt_ok_ff;
   logic                   rd_ok_ff;

   // register file state
   logic [REG_COUNT-1:0]   valid_ff;
   logic [REG_COUNT-1:0]   valid_in;
   logic                   byp_valid_ff;
   logic [IDX_FIELD_W-1:0] byp_addr_ff;
   logic [DATA_W-1:0]      byp_data_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [IDX_FIELD_W-1:0] rsp_dest_ff;
   logic [DATA_W-1:0]      rsp_value_ff;
   logic                   rsp_wrote_ff;
   logic                   rsp_unknown_ff;

   logic [IDX_FIELD_W-1:0] req_rs;
   logic [IDX_FIELD_W-1:0] req_rt;
   logic [IDX_FIELD_W-1:0] req_rd;
   logic [IDX_FIELD_W-1:0] s1_rs;
   logic [IDX_FIELD_W-1:0] s1_rt;
   logic [IDX_FIELD_W-1:0] s1_rd;
   logic [DATA_W-1:0]      q_s;
   logic [DATA_W-1:0]      q_t;
   logic [DATA_W-1:0]      q_d;
   logic [DATA_W-1:0]      opnd_s;
   logic [DATA_W-1:0]      opnd_t;
   logic [DATA_W-1:0]      opnd_d;
   alu_result_type         alu_res;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_xfer  = req_valid && req_ready;

   assign req_rs = req_instruction[25:21];
   assign req_rt = req_instruction[20:16];
   assign req_rd = req_instruction[15:11];
   assign s1_rs  = s1_instruction_ff[25:21];
   assign s1_rt  = s1_instruction_ff[20:16];
   assign s1_rd  = s1_instruction_ff[15:11];

   assign wr_en   = s1_adv && alu_res.write_req && in_range(alu_res.dest);
   assign wr_addr = alu_res.dest[ADDR_W-1:0];

   msae_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_s (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (alu_res.value),
      .rd_en   (req_xfer),
      .rd_addr (req_rs[ADDR_W-1:0]),
      .rd_data (q_s)
   );

   msae_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_t (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (alu_res.value),
      .rd_en   (req_xfer),
      .rd_addr (req_rt[ADDR_W-1:0]),
      .rd_data (q_t)
   );

   msae_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_d (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (alu_res.value),
      .rd_en   (req_xfer),
      .rd_addr (req_rd[ADDR_W-1:0]),
      .rd_data (q_d)
   );

   // bypass holds the latest write-back, which the RAM read may have missed
   always_comb begin
      opnd_s = rs_ok_ff ? q_s : '0;
      opnd_t = rt_ok_ff ? q_t : '0;
      opnd_d = rd_ok_ff ? q_d : '0;
      if (byp_valid_ff && byp_addr_ff == s1_rs) begin
         opnd_s = byp_data_ff;
      end
      if (byp_valid_ff && byp_addr_ff == s1_rt) begin
         opnd_t = byp_data_ff;
      end
      if (byp_valid_ff && byp_addr_ff == s1_rd) begin
         opnd_d = byp_data_ff;
      end
   end

   msae_alu u_alu (
      .operation   (s1_operation_ff),
      .instruction (s1_instruction_ff),
      .load_index  (s1_load_index_ff),
      .load_data   (s1_load_data_ff),
      .opnd_s      (opnd_s),
      .opnd_t      (opnd_t),
      .opnd_d      (opnd_d),
      .result      (alu_res)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            byp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_operation_ff   <= req_operation;
         s1_instruction_ff <= req_instruction;
         s1_load_index_ff  <= req_load_index;
         s1_load_data_ff   <= $unsigned(req_load_data);
         rs_ok_ff <= in_range(req_rs) && valid_in[req_rs[ADDR_W-1:0]];
         rt_ok_ff <= in_range(req_rt) && valid_in[req_rt[ADDR_W-1:0]];
         rd_ok_ff <= in_range(req_rd) && valid_in[req_rd[ADDR_W-1:0]];
      end
      if (wr_en) begin
         byp_addr_ff <= alu_res.dest;
         byp_data_ff <= alu_res.value;
      end
      if (s1_adv) begin
         rsp_dest_ff    <= alu_res.dest;
         rsp_value_ff   <= alu_res.value;
         rsp_wrote_ff   <= wr_en;
         rsp_unknown_ff <= alu_res.unknown;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dest_index   = rsp_dest_ff;
   assign rsp_result_value = $signed(rsp_value_ff);
   assign rsp_wrote        = rsp_wrote_ff;
   assign rsp_unknown_op   = rsp_unknown_ff;

endmodule

[rtl/msae_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msae_checker
// Port-level checks on the execute block, bound to the top level.
// ----------------------------------------------------------------------------
module msae_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [msae_pkg::IDX_FIELD_W-1:0]    rsp_dest_index,
   input logic signed [msae_pkg::DATA_W-1:0]  rsp_result_value,
   input logic                                rsp_wrote,
   input logic                                rsp_unknown_op
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_index)
         && $stable(rsp_result_value) && $stable(rsp_wrote) && $stable(rsp_unknown_op))
      else $error("stalled result changed");

   a_unknown_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unknown_op |-> !rsp_wrote && rsp_dest_index == '0
         && rsp_result_value == '0)
      else $error("unsupported op produced a write or a value");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without result back-pressure");

   a_accept_flows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready |=> ##1 rsp_valid)
      else $error("accepted item did not reach the result register");

endmodule

bind mips_subset_alu_execute msae_checker u_msae_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_dest_index   (rsp_dest_index),
   .rsp_result_value (rsp_result_value),
   .rsp_wrote        (rsp_wrote),
   .rsp_unknown_op   (rsp_unknown_op)
);

[verif/msae_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msae_tb_checker
// Watches both channels of the integer execute block and checks each result.
//
// Every input transfer is run through a local copy of the register file and
// the instruction decode. The predicted write-back is queued in order. Every
// result transfer is compared field by field with the oldest queued entry.
// Results with nothing queued and wrong fields add to fault_count.
// pending_count gives the number of predicted results not yet seen.
// ----------------------------------------------------------------------------
module msae_tb_checker #(
   parameter int REG_COUNT = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic [31:0]                           req_instruction,
   input  logic [msae_pkg::IDX_FIELD_W-1:0]      req_load_index,
   input  logic signed [msae_pkg::DATA_W-1:0]    req_load_data,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [msae_pkg::IDX_FIELD_W-1:0]      rsp_dest_index,
   input  logic signed [msae_pkg::DATA_W-1:0]    rsp_result_value,
   input  logic                                  rsp_wrote,
   input  logic                                  rsp_unknown_op,
   output int                                    fault_count,
   output int                                    pending_count,
   output int                                    checked_count
);
   import msae_pkg::*;

   logic [DATA_W-1:0] gpr_model [32];
   alu_result_type    expected_writebacks [$];

   function automatic logic [DATA_W-1:0] read_gpr(input logic [IDX_FIELD_W-1:0] idx);
      if (idx < REG_COUNT) return gpr_model[idx];
      return '0;
   endfunction

   task automatic execute_item(
      input  logic                   oper,
      input  logic [31:0]            word,
      input  logic [IDX_FIELD_W-1:0] load_idx,
      input  logic [DATA_W-1:0]      load_val,
      output alu_result_type         res
   );
      logic [4:0]             opc;
      logic [4:0]             rs;
      logic [4:0]             rt;
      logic [4:0]             rd;
      logic [4:0]             sa;
      logic [5:0]             fn;
      logic [DATA_W-1:0]      a;
      logic [DATA_W-1:0]      b;
      logic [DATA_W-1:0]      imm_ext;
      logic [DATA_W-1:0]      value;
      logic [IDX_FIELD_W-1:0] dest;
      logic                   known;
      known = 1'b1;
      dest  = '0;
      value = '0;
      if (oper == OPER_LOAD) begin
         dest  = load_idx;
         value = load_val;
      end else begin
         opc     = word[30:26];
         rs      = word[25:21];
         rt      = word[20:16];
         rd      = word[15:11];
         sa      = word[10:6];
         fn      = word[5:0];
         a       = read_gpr(rs);
         b       = read_gpr(rt);
         imm_ext = {{16{word[15]}}, word[15:0]};
         if (opc == OPC_SPECIAL) begin
            dest = rd;
            case (fn)
               FN_ADD:  value = a + b;
               FN_SUB:  value = a - b;
               FN_SLL:  value = b << sa;
               FN_SRL:  value = b >> sa;
               FN_AND:  value = a & b;
               FN_OR:   value = a | b;
               FN_MOVZ: value = (b == '0) ? a : read_gpr(rd);
               default: known = 1'b0;
            endcase
         end else if (opc == OPC_ADDI) begin
            dest  = rt;
            value = a + imm_ext;
         end else if (opc == OPC_MUL) begin
            dest  = rd;
            value = a * b;
         end else begin
            known = 1'b0;
         end
         if (!known) begin
            dest  = '0;
            value = '0;
         end
      end
      res.dest      = dest;
      res.value     = value;
      res.unknown   = !known;
      res.write_req = known && (dest < REG_COUNT);
      if (res.write_req) gpr_model[dest] = value;
   endtask

   task automatic report_fault(input string what, input alu_result_type want,
                               input alu_result_type got);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t fault %0d, %s: expected dest=%0d value=%h wrote=%b unknown=%b",
                  $realtime, fault_count, what, want.dest, want.value, want.write_req,
                  want.unknown);
         $display("      got dest=%0d value=%h wrote=%b unknown=%b",
                  got.dest, got.value, got.write_req, got.unknown);
      end
   endtask

   always @(posedge clock) begin
      alu_result_type got;
      alu_result_type want;
      alu_result_type fresh;
      if (reset) begin
         foreach (gpr_model[i]) gpr_model[i] = '0;
         expected_writebacks.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.dest      = rsp_dest_index;
            got.value     = rsp_result_value;
            got.write_req = rsp_wrote;
            got.unknown   = rsp_unknown_op;
            if (expected_writebacks.size() == 0) begin
               want = '0;
               report_fault("result with nothing outstanding", want, got);
            end else begin
               want = expected_writebacks.pop_front();
               checked_count++;
               if (got !== want) report_fault("field mismatch", want, got);
            end
         end
         if (req_valid && req_ready) begin
            execute_item(req_operation, req_instruction, req_load_index, req_load_data,
                         fresh);
            expected_writebacks.push_back(fresh);
         end
      end
      pending_count = expected_writebacks.size();
   end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the integer execute block.
//
// Drives a directed set of corner cases (operand extremes, every operation,
// unsupported codes, MOVZ both ways, register zero, back-to-back dependencies)
// then random load and instruction traffic. Both channels idle in random
// bursts except in a quiet tail. Checking lives in msae_tb_checker.
// ----------------------------------------------------------------------------
module testbench;
   import msae_pkg::*;

   localparam int REG_COUNT    = 32;
   localparam int RANDOM_ITEMS = 1100;
   localparam int CALM_ITEMS   = 150;
   localparam int TAIL_CYCLES  = 10;
   localparam int DRAIN_LIMIT  = 20000;

   localparam logic [4:0] OPC_UNSUP_J   = 5'd2;
   localparam logic [5:0] FN_UNSUP_JR   = 6'd8;
   localparam logic [5:0] FN_UNSUP_MULT = 6'd28;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_operation;
   logic [31:0]              req_instruction;
   logic [IDX_FIELD_W-1:0]   req_load_index;
   logic signed [DATA_W-1:0] req_load_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [IDX_FIELD_W-1:0]   rsp_dest_index;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic                     rsp_wrote;
   logic                     rsp_unknown_op;

   int fault_count;
   int pending_count;
   int checked_count;
   int sent_count;
   int load_count;
   bit calm;

   mips_subset_alu_execute #(
      .REG_COUNT (REG_COUNT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_instruction  (req_instruction),
      .req_load_index   (req_load_index),
      .req_load_data    (req_load_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_result_value (rsp_result_value),
      .rsp_wrote        (rsp_wrote),
      .rsp_unknown_op   (rsp_unknown_op)
   );

   msae_tb_checker #(
      .REG_COUNT (REG_COUNT)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_instruction  (req_instruction),
      .req_load_index   (req_load_index),
      .req_load_data    (req_load_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_result_value (rsp_result_value),
      .rsp_wrote        (rsp_wrote),
      .rsp_unknown_op   (rsp_unknown_op),
      .fault_count      (fault_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic logic [31:0] r_word(input logic [4:0] opc, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sa, input logic [5:0] fn);
      return {1'b0, opc, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] i_word(input logic [4:0] opc, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
      return {1'b0, opc, rs, rt, imm};
   endfunction

   function automatic logic [4:0] pick_reg();
      if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 3));
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [31:0] pick_data();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // hold the item until the transfer, then, outside the calm tail, sometimes idle for a random burst
   task automatic send(input logic oper, input logic [31:0] word,
                       input logic [IDX_FIELD_W-1:0] idx, input logic [DATA_W-1:0] data);
      int gap;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_operation   <= oper;
      req_instruction <= word;
      req_load_index  <= idx;
      req_load_data   <= data;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (oper == OPER_LOAD) load_count++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_exec(input logic [31:0] word);
      send(OPER_EXEC, word, 5'($urandom), $urandom);
   endtask

   task automatic send_load(input logic [IDX_FIELD_W-1:0] idx, input logic [DATA_W-1:0] data);
      send(OPER_LOAD, $urandom, idx, data);
   endtask

   initial begin
      int  burst;
      bit  stall;
      rsp_ready = 1'b0;
      forever begin
         if (calm) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            burst = $urandom_range(1, 13);
            stall = ($urandom_range(0, 2) == 0);
            repeat (burst) begin
               @(negedge clock);
               rsp_ready <= !stall;
            end
         end
      end
   end

   initial begin
      logic [31:0] word;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sa;
      int          roll;
      int          guard;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OPER_EXEC;
      req_instruction = '0;
      req_load_index  = '0;
      req_load_data   = '0;
      calm            = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_load(5'd1, 32'h7FFF_FFFF);
      send_load(5'd2, 32'h8000_0000);
      send_load(5'd3, 32'hFFFF_FFFF);
      send_load(5'd0, 32'h0000_0005);
      send_exec(r_word(OPC_SPECIAL, 5'd1, 5'd3, 5'd4, 5'd0, FN_ADD));
      send_exec(r_word(OPC_SPECIAL, 5'd2, 5'd1, 5'd5, 5'd0, FN_SUB));
      send_exec(r_word(OPC_SPECIAL, 5'd0, 5'd3, 5'd6, 5'd31, FN_SLL));
      send_exec(r_word(OPC_SPECIAL, 5'd0, 5'd1, 5'd7, 5'd0, FN_SLL));
      send_exec(r_word(OPC_SPECIAL, 5'd0, 5'd2, 5'd8, 5'd31, FN_SRL));
      send_exec(r_word(OPC_SPECIAL, 5'd1, 5'd3, 5'd9, 5'd0, FN_AND));
      send_exec(r_word(OPC_SPECIAL, 5'd2, 5'd0, 5'd10, 5'd0, FN_OR));
      send_exec(r_word(OPC_SPECIAL, 5'd1, 5'd11, 5'd12, 5'd0, FN_MOVZ));
      send_exec(r_word(OPC_SPECIAL, 5'd2, 5'd3, 5'd1, 5'd0, FN_MOVZ));
      send_exec(i_word(OPC_ADDI, 5'd1, 5'd13, 16'hFFFF));
      send_exec(i_word(OPC_ADDI, 5'd3, 5'd14, 16'h7FFF));
      send_exec(i_word(OPC_ADDI, 5'd2, 5'd15, 16'h8000));
      send_exec(r_word(OPC_MUL, 5'd3, 5'd3, 5'd16, 5'd0, 6'd0));
      send_exec(r_word(OPC_MUL, 5'd2, 5'd1, 5'd17, 5'd31, 6'h3F));
      send_exec(r_word(OPC_UNSUP_J, 5'd1, 5'd2, 5'd18, 5'd0, FN_ADD));
      send_exec(r_word(OPC_SPECIAL, 5'd1, 5'd2, 5'd19, 5'd0, FN_UNSUP_JR));
      send_exec(r_word(OPC_SPECIAL, 5'd1, 5'd2, 5'd20, 5'd0, FN_UNSUP_MULT));
      send_exec(r_word(OPC_SPECIAL, 5'd0, 5'd0, 5'd21, 5'd0, FN_ADD) | 32'h8000_0000);
      send_exec(r_word(OPC_SPECIAL, 5'd21, 5'd21, 5'd22, 5'd0, FN_ADD));
      send_load(5'd31, 32'h0000_0000);
      send_exec(r_word(OPC_SPECIAL, 5'd31, 5'd22, 5'd31, 5'd0, FN_SUB));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         roll = $urandom_range(0, 99);
         rs   = pick_reg();
         rt   = pick_reg();
         rd   = pick_reg();
         sa   = 5'($urandom);
         if (roll < 25) begin
            send_load(pick_reg(), pick_data());
         end else if (roll < 88) begin
            case ($urandom_range(0, 8))
               0: word = r_word(OPC_SPECIAL, rs, rt, rd, sa, FN_ADD);
               1: word = r_word(OPC_SPECIAL, rs, rt, rd, sa, FN_SUB);
               2: word = r_word(OPC_SPECIAL, rs, rt, rd, sa, FN_SLL);
               3: word = r_word(OPC_SPECIAL, rs, rt, rd, sa, FN_SRL);
               4: word = r_word(OPC_SPECIAL, rs, rt, rd, sa, FN_AND);
               5: word = r_word(OPC_SPECIAL, rs, rt, rd, sa, FN_OR);
               6: word = r_word(OPC_SPECIAL, rs, rt, rd, sa, FN_MOVZ);
               7: word = i_word(OPC_ADDI, rs, rt, 16'($urandom));
               default: word = r_word(OPC_MUL, rs, rt, rd, sa, 6'($urandom));
            endcase
            word[31] = 1'($urandom_range(0, 1));
            send_exec(word);
         end else if (roll < 94) begin
            word = r_word(OPC_SPECIAL, rs, rt, rd, sa, 6'($urandom));
            word[31] = 1'($urandom_range(0, 1));
            send_exec(word);
         end else begin
            send_exec($urandom);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      guard = 0;
      while (pending_count != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (pending_count != 0) $display("%0d results never arrived", pending_count);
      $display("run covered %0d input transfers (%0d loads, %0d instruction words)",
               sent_count, load_count, sent_count - load_count);
      $display("directed corners then random traffic with idling; %0d results compared",
               checked_count);
      if (fault_count == 0 && pending_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
